// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 64;
    localparam int OP_W    = 4;
    localparam int CLOSE_W = 16;
    localparam int LCODE_W = 7;

    localparam logic [LCODE_W-1:0] LEN_CODE_16 = 7'd126;
    localparam logic [LCODE_W-1:0] LEN_CODE_64 = 7'd127;

    localparam logic [OP_W-1:0] OP_CONT   = 4'h0;
    localparam logic [OP_W-1:0] OP_TEXT   = 4'h1;
    localparam logic [OP_W-1:0] OP_BINARY = 4'h2;
    localparam logic [OP_W-1:0] OP_CLOSE  = 4'h8;
    localparam logic [OP_W-1:0] OP_PING   = 4'h9;
    localparam logic [OP_W-1:0] OP_PONG   = 4'hA;

    localparam logic [3:0] PH_HDR0     = 4'd0;
    localparam logic [3:0] PH_HDR1     = 4'd1;
    localparam logic [3:0] PH_EXT64    = 4'd2;
    localparam logic [3:0] PH_EXT16    = 4'd8;
    localparam logic [3:0] PH_EXT_LAST = 4'd9;
    localparam logic [3:0] PH_PAYLOAD  = 4'd10;

    function automatic logic opcode_defined(input logic [OP_W-1:0] op);
        logic ok;
        unique case (op) inside
            OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// File: rtl/websocket_frame_deframer_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Receive-side WebSocket deframer for unmasked frames. One stream byte is taken per
// transfer and exactly one result comes back for it, registered on acceptance: header
// and extended-length bytes give is_payload 0, payload bytes pass through with their offset
// in the whole message, and the byte that finishes a FIN frame carries message_end with the
// total length, the close code of a close message and a flag for an undefined opcode.
// Continuation frames are chained into the open message, whose opcode is the one of its
// first frame. A byte is accepted only while the single output register is empty or its
// result transfer completes in that cycle, so throughput is one byte
// per clock whenever the consumer keeps ready high. Mask and reserved bits are not decoded.
module websocket_frame_deframer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [wsd_pkg::BYTE_W-1:0]       i_data_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_is_payload,
    output logic [wsd_pkg::BYTE_W-1:0]       o_payload_byte,
    output logic [wsd_pkg::CNT_W-1:0]        o_byte_offset,
    output logic [wsd_pkg::OP_W-1:0]         o_message_opcode,
    output logic                             o_message_end,
    output logic [wsd_pkg::CNT_W-1:0]        o_message_length,
    output logic [wsd_pkg::CLOSE_W-1:0]      o_close_code,
    output logic                             o_bad_opcode
);

    logic [3:0]                     r_phase, n_phase;
    logic                           r_fin, n_fin;
    logic [wsd_pkg::OP_W-1:0]       r_frame_op, n_frame_op;
    logic [wsd_pkg::CNT_W-1:0]      r_ext_len, n_ext_len;
    logic [wsd_pkg::CNT_W-1:0]      r_remaining, n_remaining;
    logic [wsd_pkg::CNT_W-1:0]      r_count, n_count;
    logic [wsd_pkg::OP_W-1:0]       r_kept_op, n_kept_op;
    logic [wsd_pkg::CLOSE_W-1:0]    r_close, n_close;

    logic                           r_out_valid;
    logic                           r_is_payload, n_is_payload;
    logic [wsd_pkg::BYTE_W-1:0]     r_payload_byte, n_payload_byte;
    logic [wsd_pkg::CNT_W-1:0]      r_byte_offset, n_byte_offset;
    logic [wsd_pkg::OP_W-1:0]       r_msg_op, n_msg_op;
    logic                           r_msg_end, n_msg_end;
    logic [wsd_pkg::CNT_W-1:0]      r_msg_len, n_msg_len;
    logic [wsd_pkg::CLOSE_W-1:0]    r_close_code, n_close_code;
    logic                           r_bad_op, n_bad_op;

    logic                           in_fire;
    logic                           start_frame;
    logic                           frame_done;
    logic [wsd_pkg::CNT_W-1:0]      start_len;
    logic [wsd_pkg::LCODE_W-1:0]    len_code;
    logic [wsd_pkg::OP_W-1:0]       w_kept_op;
    logic [wsd_pkg::CNT_W-1:0]      w_count;
    logic [wsd_pkg::CLOSE_W-1:0]    w_close;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign len_code   = i_data_byte[wsd_pkg::LCODE_W-1:0];

    always_comb begin
        n_phase        = r_phase;
        n_fin          = r_fin;
        n_frame_op     = r_frame_op;
        n_ext_len      = r_ext_len;
        n_remaining    = r_remaining;
        start_frame    = 1'b0;
        frame_done     = 1'b0;
        start_len      = r_ext_len;
        w_kept_op      = r_kept_op;
        w_count        = r_count;
        w_close        = r_close;
        n_is_payload   = 1'b0;
        n_payload_byte = '0;
        n_byte_offset  = '0;

        if (r_phase == wsd_pkg::PH_HDR0) begin
            n_fin      = i_data_byte[7];
            n_frame_op = i_data_byte[wsd_pkg::OP_W-1:0];
            n_phase    = wsd_pkg::PH_HDR1;
        end else if (r_phase == wsd_pkg::PH_HDR1) begin
            n_ext_len = '0;
            if (len_code == wsd_pkg::LEN_CODE_16) begin
                n_phase = wsd_pkg::PH_EXT16;
            end else if (len_code == wsd_pkg::LEN_CODE_64) begin
                n_phase = wsd_pkg::PH_EXT64;
            end else begin
                start_frame = 1'b1;
                start_len   = {{(wsd_pkg::CNT_W-wsd_pkg::LCODE_W){1'b0}}, len_code};
            end
        end else if (r_phase >= wsd_pkg::PH_EXT64 && r_phase <= wsd_pkg::PH_EXT_LAST) begin
            n_ext_len = {r_ext_len[wsd_pkg::CNT_W-wsd_pkg::BYTE_W-1:0], i_data_byte};
            if (r_phase == wsd_pkg::PH_EXT_LAST) begin
                start_frame = 1'b1;
                start_len   = n_ext_len;
            end else begin
                n_phase = 4'(r_phase + 4'd1);
            end
        end else begin
            n_is_payload   = 1'b1;
            n_payload_byte = i_data_byte;
            n_byte_offset  = r_count;
            if (r_kept_op == wsd_pkg::OP_CLOSE) begin
                if (r_count == '0) begin
                    w_close[15:8] = i_data_byte;
                end else if (r_count == 64'd1) begin
                    w_close[7:0] = i_data_byte;
                end
            end
            w_count     = r_count + 64'd1;
            n_remaining = r_remaining - 64'd1;
            if (r_remaining == 64'd1) begin
                n_phase    = wsd_pkg::PH_HDR0;
                frame_done = 1'b1;
            end
        end

        if (start_frame) begin
            if (r_frame_op != wsd_pkg::OP_CONT) begin
                w_kept_op = r_frame_op;
                w_count   = '0;
                w_close   = '0;
            end
            n_remaining = start_len;
            if (start_len == '0) begin
                n_phase    = wsd_pkg::PH_HDR0;
                frame_done = 1'b1;
            end else begin
                n_phase = wsd_pkg::PH_PAYLOAD;
            end
        end

        n_msg_op     = w_kept_op;
        n_msg_end    = frame_done && r_fin;
        n_msg_len    = n_msg_end ? w_count : '0;
        n_close_code = (n_msg_end && w_kept_op == wsd_pkg::OP_CLOSE && w_count >= 64'd2)
                       ? w_close : '0;
        n_bad_op     = n_msg_end && !wsd_pkg::opcode_defined(w_kept_op);

        n_kept_op = n_msg_end ? '0 : w_kept_op;
        n_count   = n_msg_end ? '0 : w_count;
        n_close   = n_msg_end ? '0 : w_close;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wsd_pkg::PH_HDR0;
            r_fin       <= 1'b0;
            r_frame_op  <= '0;
            r_ext_len   <= '0;
            r_remaining <= '0;
            r_count     <= '0;
            r_kept_op   <= '0;
            r_close     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase     <= n_phase;
                r_fin       <= n_fin;
                r_frame_op  <= n_frame_op;
                r_ext_len   <= n_ext_len;
                r_remaining <= n_remaining;
                r_count     <= n_count;
                r_kept_op   <= n_kept_op;
                r_close     <= n_close;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_is_payload   <= n_is_payload;
            r_payload_byte <= n_payload_byte;
            r_byte_offset  <= n_byte_offset;
            r_msg_op       <= n_msg_op;
            r_msg_end      <= n_msg_end;
            r_msg_len      <= n_msg_len;
            r_close_code   <= n_close_code;
            r_bad_op       <= n_bad_op;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_is_payload     = r_is_payload;
    assign o_payload_byte   = r_payload_byte;
    assign o_byte_offset    = r_byte_offset;
    assign o_message_opcode = r_msg_op;
    assign o_message_end    = r_msg_end;
    assign o_message_length = r_msg_len;
    assign o_close_code     = r_close_code;
    assign o_bad_opcode     = r_bad_op;

    `ASSERT_NEVER(a_phase_range, i_clk, i_rst_n, r_phase > wsd_pkg::PH_PAYLOAD, "phase out of range")
    `ASSERT_AT(a_payload_open, i_clk, i_rst_n, (r_phase == wsd_pkg::PH_PAYLOAD) |-> (r_remaining != '0), "payload phase with no bytes left")
    `ASSERT_AT(a_frame_close, i_clk, i_rst_n, (in_fire && r_phase == wsd_pkg::PH_PAYLOAD && r_remaining == 64'd1) |=> (r_phase == wsd_pkg::PH_HDR0), "frame did not close on last byte")
    `ASSERT_AT(a_hdr_result, i_clk, i_rst_n, (r_out_valid && !r_is_payload) |-> (r_byte_offset == '0 && r_payload_byte == '0), "header result carries payload data")
    `ASSERT_AT(a_end_fields, i_clk, i_rst_n, (r_out_valid && !r_msg_end) |-> (r_msg_len == '0 && r_close_code == '0 && !r_bad_op), "end fields set without message end")

endmodule
